[sv/plmbc_pkg.sv]
`default_nettype none
package plmbc_pkg;

  localparam int unsigned MAX_LINKS = 32;
  localparam int unsigned IDX_W     = $clog2(MAX_LINKS);
  localparam int unsigned CNT_W     = 6;

  localparam logic [31:0] ERASED_ADDR = 32'hFFFF_FFFF;

  // action codes, 3 bits each
  localparam logic [2:0] ACT_OPEN   = 3'd0;
  localparam logic [2:0] ACT_STOP   = 3'd1;
  localparam logic [2:0] ACT_CLOSE  = 3'd2;
  localparam logic [2:0] ACT_TOGGLE = 3'd3;

  localparam logic [7:0] LVL_OPEN   = 8'd200;
  localparam logic [7:0] LVL_STOP   = 8'd201;
  localparam logic [7:0] LVL_CLOSE  = 8'd0;
  localparam logic [7:0] LVL_TOGGLE = 8'd255;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_EVENT = 1'b1;

  typedef struct packed {
    logic [31:0] addr;
    logic [7:0]  snd_ch;
    logic [7:0]  tgt_ch;
    logic [7:0]  action;
  } link_t;

  // one queued request between front and back
  typedef struct packed {
    logic             req_type;
    logic [IDX_W-1:0] entry_index;
    logic [31:0]      sender_addr;
    logic [7:0]       sender_channel;
    logic [7:0]       target_channel;
    logic [7:0]       action_byte;
    logic             long_press;
  } req_t;

  function automatic logic act_active(input logic [2:0] code);
    logic r;
    r = 1'b0;
    case (code)
      ACT_OPEN, ACT_STOP, ACT_CLOSE, ACT_TOGGLE: r = 1'b1;
      default:                                    r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] act_level(input logic [2:0] code);
    logic [7:0] r;
    r = LVL_CLOSE;
    case (code)
      ACT_OPEN:   r = LVL_OPEN;
      ACT_STOP:   r = LVL_STOP;
      ACT_CLOSE:  r = LVL_CLOSE;
      ACT_TOGGLE: r = LVL_TOGGLE;
      default:    r = LVL_CLOSE;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

[sv/plmbc_front.sv]
`default_nettype none
module plmbc_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire plmbc_pkg::req_t in_req,
  output logic                 q_valid,
  output plmbc_pkg::req_t      q_req,
  input  wire logic            q_pop
);

  // two-entry request queue
  plmbc_pkg::req_t buf_r [2];
  logic            wr_ptr_r, wr_ptr_nxt;
  logic            rd_ptr_r, rd_ptr_nxt;
  logic [1:0]      cnt_r, cnt_nxt;
  logic            push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_req    = buf_r[rd_ptr_r];
  assign push     = in_valid & in_ready;
  assign pop      = q_pop & q_valid;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= in_req;
    end
  end

endmodule
`default_nettype wire

[sv/plmbc_back.sv]
`default_nettype none
module plmbc_back (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic [plmbc_pkg::CNT_W-1:0] link_count,
  input  wire logic                       q_valid,
  input  wire plmbc_pkg::req_t            q_req,
  output logic                            q_pop,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic                            out_cmd,
  output logic [7:0]                      out_chan,
  output logic [7:0]                      out_lvl,
  output logic                            out_last
);

  typedef enum logic {ST_IDLE, ST_SCAN} state_t;

  state_t                         state_r, state_nxt;
  logic [plmbc_pkg::CNT_W-1:0]    idx_r, idx_nxt;
  logic [plmbc_pkg::CNT_W-1:0]    scan_n;
  logic                           s_vld_r, s_vld_nxt;
  logic                           s_ok_r;
  plmbc_pkg::link_t               s_data_r;
  logic [plmbc_pkg::MAX_LINKS-1:0] vbits_r, vbits_nxt;
  plmbc_pkg::link_t               mem [plmbc_pkg::MAX_LINKS];

  logic [31:0] ev_addr_r;
  logic [7:0]  ev_sch_r, ev_tch_r;
  logic        ev_lp_r;

  logic        out_valid_r, out_valid_nxt;
  logic        out_cmd_r, out_cmd_nxt;
  logic [7:0]  out_chan_r, out_chan_nxt;
  logic [7:0]  out_lvl_r, out_lvl_nxt;
  logic        out_last_r, out_last_nxt;

  logic        out_free, hit, stall, rd_en, wr_en, take_ev, end_go;
  logic [2:0]  code;

  assign scan_n = (link_count > plmbc_pkg::CNT_W'(plmbc_pkg::MAX_LINKS)) ?
                  plmbc_pkg::CNT_W'(plmbc_pkg::MAX_LINKS) : link_count;

  assign out_free = !out_valid_r || out_ready;
  assign code     = ev_lp_r ? s_data_r.action[5:3] : s_data_r.action[2:0];
  assign hit      = s_vld_r && s_ok_r &&
                    (s_data_r.addr != plmbc_pkg::ERASED_ADDR) &&
                    (s_data_r.addr == ev_addr_r) &&
                    (s_data_r.snd_ch == ev_sch_r) &&
                    (s_data_r.tgt_ch == ev_tch_r) &&
                    plmbc_pkg::act_active(code);
  assign stall    = hit && !out_free;
  assign rd_en    = (state_r == ST_SCAN) && (idx_r < scan_n) && !stall;
  assign end_go   = (state_r == ST_SCAN) && (idx_r >= scan_n) && !s_vld_r && out_free;

  assign q_pop    = (state_r == ST_IDLE) && q_valid;
  assign take_ev  = q_pop && (q_req.req_type == plmbc_pkg::REQ_EVENT);
  assign wr_en    = q_pop && (q_req.req_type == plmbc_pkg::REQ_WRITE);

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    s_vld_nxt     = stall ? s_vld_r : rd_en;
    vbits_nxt     = vbits_r;
    out_valid_nxt = out_valid_r;
    out_cmd_nxt   = out_cmd_r;
    out_chan_nxt  = out_chan_r;
    out_lvl_nxt   = out_lvl_r;
    out_last_nxt  = out_last_r;

    if (wr_en) begin
      vbits_nxt[q_req.entry_index] = 1'b1;
    end
    if (take_ev) begin
      state_nxt = ST_SCAN;
      idx_nxt   = '0;
    end
    if (rd_en) begin
      idx_nxt = idx_r + plmbc_pkg::CNT_W'(1);
    end

    if (hit && out_free) begin
      out_valid_nxt = 1'b1;
      out_cmd_nxt   = 1'b1;
      out_chan_nxt  = ev_tch_r;
      out_lvl_nxt   = plmbc_pkg::act_level(code);
      out_last_nxt  = 1'b0;
    end else if (end_go) begin
      out_valid_nxt = 1'b1;
      out_cmd_nxt   = 1'b0;
      out_chan_nxt  = 8'd0;
      out_lvl_nxt   = 8'd0;
      out_last_nxt  = 1'b1;
      state_nxt     = ST_IDLE;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      s_vld_r     <= 1'b0;
      vbits_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      s_vld_r     <= s_vld_nxt;
      vbits_r     <= vbits_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_cmd_r  <= out_cmd_nxt;
    out_chan_r <= out_chan_nxt;
    out_lvl_r  <= out_lvl_nxt;
    out_last_r <= out_last_nxt;
    if (take_ev) begin
      ev_addr_r <= q_req.sender_addr;
      ev_sch_r  <= q_req.sender_channel;
      ev_tch_r  <= q_req.target_channel;
      ev_lp_r   <= q_req.long_press;
    end
  end

  // link table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[q_req.entry_index] <= '{addr:   q_req.sender_addr,
                                  snd_ch: q_req.sender_channel,
                                  tgt_ch: q_req.target_channel,
                                  action: q_req.action_byte};
    end
    if (rd_en) begin
      s_data_r <= mem[idx_r[plmbc_pkg::IDX_W-1:0]];
      s_ok_r   <= vbits_r[idx_r[plmbc_pkg::IDX_W-1:0]];
    end
  end

  assign out_valid = out_valid_r;
  assign out_cmd   = out_cmd_r;
  assign out_chan  = out_chan_r;
  assign out_lvl   = out_lvl_r;
  assign out_last  = out_last_r;

endmodule
`default_nettype wire

[sv/peer_link_match_blind_command.sv]
// Peering-link matcher for blind actuators.
// Input stream (in_*): one beat is either a link-table write (in_tuser = 0)
// or a key event (in_tuser = 1). Writes store one 56-bit link entry and
// produce no output. A key event scans entries 0 .. min(link_count,32)-1
// and emits one set-level beat (out_tuser = 1) per matching active link,
// then an end marker beat (out_tuser = 0, out_tlast = 1, data zero).
// Config (cfg_*): link_count, always accepted; write only while idle.
// Scan: with n = min(link_count, 32), the event is taken from the queue,
// entries 0 .. n-1 are read in order through the single registered read
// port of the link table and compared with the event, and the end marker
// follows the last one; the scan reads one table entry per cycle except
// while a match waits on a stalled receiver. A write starts no scan.
// A two-beat request queue sits between the front and the scanner, so
// input beats keep being taken while a scan runs, until the queue fills.
// Receiver stall (out_tready low) holds the output register and freezes
// the scan at the pending match; nothing is dropped or repeated.
// Reset: link_count = 0, queue empty, every table entry reads as erased
// (per-entry valid flags cleared; no clearing pass needed).
`default_nettype none
module peer_link_match_blind_command (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // in_tdata: entry_index[4:0], sender_addr[36:5], sender_channel[44:37],
  //           target_channel[52:45], action_byte[60:53], long_press[61]
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,
  input  wire logic        in_tuser,   // req_type
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // out_channel[7:0], out_level[15:8]
  output logic             out_tuser,  // cmd_valid
  output logic             out_tlast,  // last
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [5:0]  cfg_data    // link_count
);

  logic [plmbc_pkg::CNT_W-1:0] link_count_r;
  plmbc_pkg::req_t             in_req, q_req;
  logic                        q_valid, q_pop;
  logic [7:0]                  o_chan, o_lvl;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_count_r <= '0;
    end else if (cfg_valid) begin
      link_count_r <= cfg_data;
    end
  end

  // unpack the input beat; top two data bits are padding
  assign in_req = '{req_type:       in_tuser,
                    entry_index:    in_tdata[4:0],
                    sender_addr:    in_tdata[36:5],
                    sender_channel: in_tdata[44:37],
                    target_channel: in_tdata[52:45],
                    action_byte:    in_tdata[60:53],
                    long_press:     in_tdata[61]};

  plmbc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_req   (in_req),
    .q_valid  (q_valid),
    .q_req    (q_req),
    .q_pop    (q_pop)
  );

  plmbc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .link_count (link_count_r),
    .q_valid    (q_valid),
    .q_req      (q_req),
    .q_pop      (q_pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_cmd    (out_tuser),
    .out_chan   (o_chan),
    .out_lvl    (o_lvl),
    .out_last   (out_tlast)
  );

  assign out_tdata = {o_lvl, o_chan};

endmodule
`default_nettype wire
